### hdl/i8alu_pkg.sv
// ----------------------------------------------------------------------------
// i8alu_pkg
// Shared widths, operation codes and pipeline stage word for the 8-bit ALU.
// ----------------------------------------------------------------------------
package i8alu_pkg;

   localparam int DATA_W     = 8;
   localparam int OP_W       = 4;
   localparam int PROD_W     = 2 * DATA_W;
   localparam int NUM_STAGES = 5;
   // divider steps done in each of the stages after the first
   localparam int DIV_STEPS  = DATA_W / (NUM_STAGES - 1);

   typedef enum logic [OP_W-1:0] {
      OP_ADD_CHK = 4'd0,
      OP_ADD     = 4'd1,
      OP_SUB_CHK = 4'd2,
      OP_SUB     = 4'd3,
      OP_MUL_CHK = 4'd4,
      OP_MUL     = 4'd5,
      OP_DIV     = 4'd6,
      OP_REM     = 4'd7,
      OP_EQ      = 4'd8,
      OP_GT      = 4'd9,
      OP_AND     = 4'd10,
      OP_OR      = 4'd11,
      OP_XOR     = 4'd12,
      OP_NOT     = 4'd13,
      OP_SHL     = 4'd14,
      OP_SHR     = 4'd15
   } op_type;

   // one pipeline stage word
   typedef struct packed {
      op_type                    op;
      logic signed [DATA_W-1:0]  opa;
      logic signed [DATA_W-1:0]  opb;
      logic [DATA_W-1:0]         value;    // result of ops computed in stage 1
      logic                      error;    // add/sub overflow, div/rem faults
      logic [PROD_W-1:0]         prod;
      logic [DATA_W-1:0]         rem_part; // divider partial remainder
      logic [DATA_W-1:0]         quo;      // dividend in, quotient out
      logic [DATA_W-1:0]         divisor;  // divisor magnitude
      logic                      q_neg;
      logic                      r_neg;
   } stage_type;

endpackage

### hdl/int8_alu_with_overflow.sv
// ----------------------------------------------------------------------------
// int8_alu_with_overflow
// Pipelined signed 8-bit ALU: add, sub, mul (checked and wrapping), divide,
// remainder, compare, logic and shifts, with an error flag.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | word
//   --------+--------------------+------------------------------------------
//   request | req_valid/req_stall | req_operation, req_operand_a, req_operand_b
//   result  | rsp_valid/rsp_stall | rsp_value, rsp_error
//
// One word enters per cycle when the result side does not stall; each word
// passes five pipeline stages plus the output register.
// The divider sets the depth: 8 restoring steps, two per stage in stages 2-5.
// Each stage holds its word until the next one frees up, so bubbles are
// squeezed out and a stall loses or repeats nothing.
// Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module int8_alu_with_overflow (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [i8alu_pkg::OP_W-1:0]             req_operation,
   input  logic signed [i8alu_pkg::DATA_W-1:0]    req_operand_a,
   input  logic signed [i8alu_pkg::DATA_W-1:0]    req_operand_b,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [i8alu_pkg::DATA_W-1:0]    rsp_value,
   output logic                                   rsp_error
);

   localparam int N = i8alu_pkg::NUM_STAGES;
   localparam int W = i8alu_pkg::DATA_W;

   i8alu_pkg::stage_type pipe_ff [N];
   i8alu_pkg::stage_type pipe_in [N];
   logic [N-1:0]         vld_ff;

   // adv[i]: stage i takes a new word this cycle; adv[N] is the output reg
   logic [N:0]           adv;

   logic                 rsp_valid_ff;
   logic [W-1:0]         rsp_value_ff;
   logic                 rsp_error_ff;
   logic [W-1:0]         rsp_value_in;
   logic                 rsp_error_in;

   // one restoring division step on magnitudes
   function automatic i8alu_pkg::stage_type div_step(input i8alu_pkg::stage_type s);
      i8alu_pkg::stage_type r;
      logic [W-1:0]         shifted;
      r       = s;
      shifted = {s.rem_part[W-2:0], s.quo[W-1]};
      r.quo   = {s.quo[W-2:0], 1'b0};
      if (shifted >= s.divisor) begin
         r.rem_part = shifted - s.divisor;
         r.quo[0]   = 1'b1;
      end else begin
         r.rem_part = shifted;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- flow
   always_comb begin
      adv[N] = !rsp_valid_ff || !rsp_stall;
      for (int i = N - 1; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[0];

   // ---------------------------------------------------------------- stage 1
   // ops computed in this stage, divide faults and magnitudes for the divider
   always_comb begin
      logic [W:0] sum9;
      logic [W:0] diff9;
      logic       add_ovf;
      logic       sub_ovf;
      logic       cnt_ok;

      sum9    = {req_operand_a[W-1], req_operand_a} + {req_operand_b[W-1], req_operand_b};
      diff9   = {req_operand_a[W-1], req_operand_a} - {req_operand_b[W-1], req_operand_b};
      add_ovf = sum9[W] ^ sum9[W-1];
      sub_ovf = diff9[W] ^ diff9[W-1];
      cnt_ok  = (req_operand_b[W-1:3] == '0);

      pipe_in[0]          = '0;
      pipe_in[0].op       = i8alu_pkg::op_type'(req_operation);
      pipe_in[0].opa      = req_operand_a;
      pipe_in[0].opb      = req_operand_b;
      pipe_in[0].quo      = req_operand_a[W-1] ? W'(-req_operand_a) : req_operand_a;
      pipe_in[0].divisor  = req_operand_b[W-1] ? W'(-req_operand_b) : req_operand_b;
      pipe_in[0].q_neg    = req_operand_a[W-1] ^ req_operand_b[W-1];
      pipe_in[0].r_neg    = req_operand_a[W-1];

      case (i8alu_pkg::op_type'(req_operation))
         i8alu_pkg::OP_ADD_CHK: begin
            pipe_in[0].error = add_ovf;
            pipe_in[0].value = add_ovf ? '0 : sum9[W-1:0];
         end
         i8alu_pkg::OP_ADD: pipe_in[0].value = sum9[W-1:0];
         i8alu_pkg::OP_SUB_CHK: begin
            pipe_in[0].error = sub_ovf;
            pipe_in[0].value = sub_ovf ? '0 : diff9[W-1:0];
         end
         i8alu_pkg::OP_SUB: pipe_in[0].value = diff9[W-1:0];
         i8alu_pkg::OP_DIV: begin
            pipe_in[0].error = (req_operand_b == '0) ||
                               (req_operand_a == {1'b1, {(W-1){1'b0}}} &&
                                req_operand_b == '1);
         end
         i8alu_pkg::OP_REM: pipe_in[0].error = (req_operand_b == '0);
         i8alu_pkg::OP_EQ:
            pipe_in[0].value = W'(req_operand_a == req_operand_b);
         i8alu_pkg::OP_GT:
            pipe_in[0].value = W'(req_operand_a > req_operand_b);
         i8alu_pkg::OP_AND: pipe_in[0].value = req_operand_a & req_operand_b;
         i8alu_pkg::OP_OR:  pipe_in[0].value = req_operand_a | req_operand_b;
         i8alu_pkg::OP_XOR: pipe_in[0].value = req_operand_a ^ req_operand_b;
         i8alu_pkg::OP_NOT: pipe_in[0].value = ~req_operand_a;
         i8alu_pkg::OP_SHL:
            pipe_in[0].value = cnt_ok ? W'(req_operand_a << req_operand_b[2:0]) : '0;
         i8alu_pkg::OP_SHR:
            pipe_in[0].value = cnt_ok ? W'(req_operand_a >> req_operand_b[2:0]) : '0;
         default: pipe_in[0].value = '0;
      endcase
   end

   // ---------------------------------------------------------------- stages 2..N
   // multiply in stage 2, two divider steps per stage
   for (genvar g = 1; g < N; g++) begin : g_stage
      always_comb begin
         i8alu_pkg::stage_type s;
         s = pipe_ff[g-1];
         if (g == 1) begin
            s.prod = i8alu_pkg::PROD_W'($signed(pipe_ff[g-1].opa)) *
                     i8alu_pkg::PROD_W'($signed(pipe_ff[g-1].opb));
         end
         for (int j = 0; j < i8alu_pkg::DIV_STEPS; j++) begin
            s = div_step(s);
         end
         pipe_in[g] = s;
      end
   end

   // ---------------------------------------------------------------- output select
   always_comb begin
      i8alu_pkg::stage_type s;
      logic                 mul_ovf;
      s       = pipe_ff[N-1];
      mul_ovf = !((s.prod[i8alu_pkg::PROD_W-1:W-1] == '0) ||
                  (s.prod[i8alu_pkg::PROD_W-1:W-1] == '1));
      rsp_error_in = s.error;
      rsp_value_in = s.value;
      case (s.op)
         i8alu_pkg::OP_MUL_CHK: begin
            rsp_error_in = mul_ovf;
            rsp_value_in = mul_ovf ? '0 : s.prod[W-1:0];
         end
         i8alu_pkg::OP_MUL: rsp_value_in = s.prod[W-1:0];
         i8alu_pkg::OP_DIV: begin
            if (s.error)      rsp_value_in = '0;
            else if (s.q_neg) rsp_value_in = W'(-s.quo);
            else              rsp_value_in = s.quo;
         end
         i8alu_pkg::OP_REM: begin
            if (s.error)      rsp_value_in = '0;
            else if (s.r_neg) rsp_value_in = W'(-s.rem_part);
            else              rsp_value_in = s.rem_part;
         end
         default: rsp_value_in = s.value;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int i = 1; i < N; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
         if (adv[N]) begin
            rsp_valid_ff <= vld_ff[N-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < N; i++) begin
         if (adv[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
      if (adv[N]) begin
         rsp_value_ff <= rsp_value_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

endmodule

### hdl/i8alu_checker.sv
// ----------------------------------------------------------------------------
// i8alu_checker
// Port-level checks for the 8-bit ALU, bound to the top level.
// ----------------------------------------------------------------------------
module i8alu_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic signed [i8alu_pkg::DATA_W-1:0]    rsp_value,
   input logic                                   rsp_error
);

   // a faulted word always carries a zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_value == '0)
      else $error("error word with nonzero value");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

   // a stalled result word stays
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped under stall");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_value) && $stable(rsp_error))
      else $error("result word changed under stall");

endmodule

bind int8_alu_with_overflow i8alu_checker u_i8alu_checker (.*);
